### rtl/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int PRIO_BITS = 16;
  localparam int TAG_BITS  = 16;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_DROPPED = 2'd2
  } stat_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_HOLD = 1'b1
  } fsm_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  insert;
    logic  pop;
    logic  capture;
    stat_t result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

### rtl/sorted_priority_queue_unit.sv
// A command's result is registered and valid from the cycle after it is accepted.
// Throughput: one command per cycle while out_ready is high; all slots compare and
// shift in parallel; the next command enters in the cycle the last result leaves.
// Reset (rst, synchronous): the queue is emptied and no result is pending; the
// slot contents are left as they are and are never read before being written.
module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [PRIO_BITS-1:0] priority_req,
  input  logic [TAG_BITS-1:0]  tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic                 head_valid,
  output logic [TAG_BITS-1:0]  head_tag,
  output logic [PRIO_BITS-1:0] head_priority,
  output logic [CNT_BITS-1:0]  entry_count
);

  cmd_t       cmd;
  dp_status_t dp_status;

  spq_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  spq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .priority_req  (priority_req),
    .tag           (tag),
    .dp_status     (dp_status),
    .status        (status),
    .head_valid    (head_valid),
    .head_tag      (head_tag),
    .head_priority (head_priority),
    .entry_count   (entry_count)
  );

endmodule

### rtl/spq_datapath.sv
module spq_datapath
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [PRIO_BITS-1:0] priority_req,
  input  logic [TAG_BITS-1:0]  tag,
  output dp_status_t           dp_status,
  output logic [1:0]           status,
  output logic                 head_valid,
  output logic [TAG_BITS-1:0]  head_tag,
  output logic [PRIO_BITS-1:0] head_priority,
  output logic [CNT_BITS-1:0]  entry_count
);

  logic [PRIO_BITS-1:0] slot_priority [CAPACITY];
  logic [TAG_BITS-1:0]  slot_tag      [CAPACITY];
  logic [PRIO_BITS-1:0] slot_priority_next [CAPACITY];
  logic [TAG_BITS-1:0]  slot_tag_next      [CAPACITY];
  logic [CNT_BITS-1:0]  fill_count;
  logic [CNT_BITS-1:0]  fill_count_next;
  logic [CAPACITY-1:0]  ge;
  stat_t                result_code;

  // Each held slot whose priority is at least the new one keeps its entry.
  // Since the array is sorted these flags form a prefix of the slots.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (fill_count > CNT_BITS'(i)) && (slot_priority[i] >= priority_req);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_priority_next[i] = slot_priority[i];
      slot_tag_next[i]      = slot_tag[i];
      if (cmd.insert) begin
        if (!ge[i]) begin
          if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
            slot_priority_next[i] = priority_req;
            slot_tag_next[i]      = tag;
          end else begin
            slot_priority_next[i] = slot_priority[(i == 0) ? 0 : i - 1];
            slot_tag_next[i]      = slot_tag[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (cmd.pop && i < CAPACITY - 1) begin
        slot_priority_next[i] = slot_priority[(i < CAPACITY - 1) ? i + 1 : i];
        slot_tag_next[i]      = slot_tag[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    if (cmd.insert) begin
      fill_count_next = fill_count + CNT_BITS'(1);
    end else if (cmd.pop) begin
      fill_count_next = fill_count - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_priority[i] <= slot_priority_next[i];
      slot_tag[i]      <= slot_tag_next[i];
    end
    if (cmd.capture) begin
      result_code <= cmd.result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  assign dp_status.empty = (fill_count == '0);
  assign dp_status.full  = (fill_count == CNT_BITS'(CAPACITY));

  // The count and the slots only move when a command is captured, so the
  // head seen here belongs to the held result.
  assign status        = result_code;
  assign head_valid    = (fill_count != '0);
  assign head_tag      = head_valid ? slot_tag[0] : '0;
  assign head_priority = head_valid ? slot_priority[0] : '0;
  assign entry_count   = fill_count;

endmodule

### rtl/spq_controller.sv
module spq_controller
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t dp_status,
  output cmd_t       cmd
);

  fsm_t state;
  fsm_t state_next;
  logic accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = FSM_HOLD;
        end
      end
      FSM_HOLD: begin
        if (out_ready && !in_valid) begin
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A transaction can be taken when idle, or in the cycle the held result leaves.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      FSM_IDLE: begin
        in_ready = 1'b1;
      end
      FSM_HOLD: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.insert  = 1'b0;
    cmd.pop     = 1'b0;
    cmd.capture = accept;
    cmd.result  = STAT_DONE;
    case (opcode)
      OP_INSERT: begin
        if (dp_status.full) begin
          cmd.result = STAT_DROPPED;
        end else begin
          cmd.insert = accept;
        end
      end
      OP_POP: begin
        if (dp_status.empty) begin
          cmd.result = STAT_EMPTY;
        end else begin
          cmd.pop = accept;
        end
      end
      default: begin
        if (dp_status.empty) begin
          cmd.result = STAT_EMPTY;
        end
      end
    endcase
  end

endmodule
